>>> hdl/fed_pkg.sv
`default_nettype none
// Shared types, constants and fixed-point helpers for the feedback echo delay.
package fed_pkg;

    localparam int unsigned SMP_W   = 24;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned PCT_N   = 128;
    localparam int unsigned RST_PCT = 50;
    localparam int unsigned MIX_MAX = 100;   // wet share saturates here
    localparam int unsigned FB_CAP  = 95;    // feedback saturates here
    localparam int unsigned PCT_DEN = 100;
    localparam int unsigned Q16_ONE = 65536;
    localparam int unsigned MS_DEN  = 1000;
    localparam int unsigned MIX_W   = 17;    // 0 .. 1.0 in Q1.16
    localparam int unsigned FB_W    = 16;    // 0 .. 0.95 in Q0.16
    localparam int unsigned PROD_W  = 41;
    localparam int unsigned ACC_W   = 42;
    localparam int unsigned APB_AW  = 4;
    localparam int unsigned APB_DW  = 32;

    localparam logic [1:0] REG_TIME   = 2'd0;
    localparam logic [1:0] REG_MIX    = 2'd1;
    localparam logic [1:0] REG_REPEAT = 2'd2;

    typedef logic signed [SMP_W-1:0]  t_smp;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef struct packed {
        logic [MIX_W-1:0] mix;
        logic [MIX_W-1:0] dry;
        logic [FB_W-1:0]  fb;
    } t_coef;

    typedef struct packed {
        logic accept;   // input item taken this edge
        logic move1;    // stage 1 item moves on, delay line written
        logic move2;    // stage 2 item moves into the output register
    } t_pipe_ctl;

    localparam t_acc ACC_MAX = t_acc'(8388607);
    localparam t_acc ACC_MIN = ~ACC_MAX;

    // floor((v + 2^15) / 2^16)
    function automatic t_acc rnd_q16(input t_acc v);
        t_acc t;
        t = v + t_acc'(32768);
        return t >>> 16;
    endfunction

    function automatic t_smp sat_smp(input t_acc v);
        t_smp r;
        if (v > ACC_MAX) begin
            r = t_smp'(ACC_MAX);
        end else if (v < ACC_MIN) begin
            r = t_smp'(ACC_MIN);
        end else begin
            r = t_smp'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/fed_cfg.sv
`default_nettype none
// APB register file with coefficient and delay lookup tables.
module fed_cfg #(
    parameter int unsigned DEPTH        = 24000,
    parameter int unsigned SAMPLE_RATE  = 48000,
    parameter int unsigned MAX_DELAY_MS = 500,
    parameter int unsigned IDX_W        = 15
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [fed_pkg::APB_AW-1:0] paddr,
    input  wire logic [fed_pkg::APB_DW-1:0] pwdata,
    output logic      [fed_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output fed_pkg::t_coef                  o_coef,
    output logic      [IDX_W-1:0]           o_delay
);
    import fed_pkg::*;

    logic [MIX_W-1:0] w_mix_tab [PCT_N];
    logic [MIX_W-1:0] w_dry_tab [PCT_N];
    logic [FB_W-1:0]  w_fb_tab  [PCT_N];
    logic [IDX_W-1:0] w_dly_tab [PCT_N];

    // constant tables, one entry per possible percent code
    for (genvar g = 0; g < PCT_N; g++) begin : g_tab
        localparam int unsigned PM   = (g > MIX_MAX) ? MIX_MAX : g;
        localparam int unsigned PR   = (g > FB_CAP) ? FB_CAP : g;
        localparam int unsigned MIXV = (PM * Q16_ONE + PCT_DEN / 2) / PCT_DEN;
        localparam int unsigned FBV  = (PR * Q16_ONE + PCT_DEN / 2) / PCT_DEN;
        localparam int unsigned MS   = (g * MAX_DELAY_MS) / PCT_DEN;
        localparam int unsigned DRAW = (MS * SAMPLE_RATE) / MS_DEN;
        localparam int unsigned DCL  = (DRAW >= DEPTH) ? DEPTH - 1 :
                                       ((DRAW == 0) ? 1 : DRAW);
        assign w_mix_tab[g] = MIX_W'(MIXV);
        assign w_dry_tab[g] = MIX_W'(Q16_ONE - MIXV);
        assign w_fb_tab[g]  = FB_W'(FBV);
        assign w_dly_tab[g] = IDX_W'(DCL);
    end

    logic [PCT_W-1:0] r_time, r_mix, r_rep;
    logic [PCT_W-1:0] n_time, n_mix, n_rep;
    t_coef            r_coef, n_coef;
    logic [IDX_W-1:0] r_delay, n_delay;
    logic             w_wen;
    logic [PCT_W-1:0] w_val;

    assign pready = 1'b1;
    assign w_wen  = psel && penable && pwrite;
    assign w_val  = pwdata[PCT_W-1:0];

    always_comb begin
        n_time  = r_time;
        n_mix   = r_mix;
        n_rep   = r_rep;
        n_coef  = r_coef;
        n_delay = r_delay;
        if (w_wen) begin
            case (paddr[3:2])
                REG_TIME: begin
                    n_time  = w_val;
                    n_delay = w_dly_tab[w_val];
                end
                REG_MIX: begin
                    n_mix      = w_val;
                    n_coef.mix = w_mix_tab[w_val];
                    n_coef.dry = w_dry_tab[w_val];
                end
                REG_REPEAT: begin
                    n_rep     = w_val;
                    n_coef.fb = w_fb_tab[w_val];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time     <= PCT_W'(RST_PCT);
            r_mix      <= PCT_W'(RST_PCT);
            r_rep      <= PCT_W'(RST_PCT);
            r_coef.mix <= w_mix_tab[PCT_W'(RST_PCT)];
            r_coef.dry <= w_dry_tab[PCT_W'(RST_PCT)];
            r_coef.fb  <= w_fb_tab[PCT_W'(RST_PCT)];
            r_delay    <= w_dly_tab[PCT_W'(RST_PCT)];
        end else begin
            r_time  <= n_time;
            r_mix   <= n_mix;
            r_rep   <= n_rep;
            r_coef  <= n_coef;
            r_delay <= n_delay;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TIME:   prdata = APB_DW'(r_time);
            REG_MIX:    prdata = APB_DW'(r_mix);
            REG_REPEAT: prdata = APB_DW'(r_rep);
            default:    prdata = '0;
        endcase
    end

    assign o_coef  = r_coef;
    assign o_delay = r_delay;

endmodule
`default_nettype wire

>>> hdl/fed_dline.sv
`default_nettype none
// Delay memory with write index, fill count and read-after-write bypass.
module fed_dline #(
    parameter int unsigned DEPTH = 24000,
    parameter int unsigned IDX_W = 15
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fed_pkg::t_pipe_ctl i_ctl,
    input  wire logic [IDX_W-1:0]   i_delay,
    input  wire fed_pkg::t_smp      i_store,
    output fed_pkg::t_smp           o_delayed
);
    import fed_pkg::*;

    localparam int unsigned FILL_W = $clog2(DEPTH + 1);

    t_smp              mem [DEPTH];
    t_smp              r_rdata;
    t_smp              r_fwd_data;
    logic              r_fwd;
    logic              r_rd_ok;
    logic [IDX_W-1:0]  r_widx, n_widx;
    logic [IDX_W-1:0]  r_w1;
    logic [FILL_W-1:0] r_fill;
    logic [IDX_W:0]    w_back;
    logic [IDX_W-1:0]  w_raddr;

    // read address = write index - delay, modulo depth
    always_comb begin
        if (r_widx >= i_delay) begin
            w_back = {1'b0, r_widx} - {1'b0, i_delay};
        end else begin
            w_back = {1'b0, r_widx} + (IDX_W + 1)'(DEPTH) - {1'b0, i_delay};
        end
        w_raddr = w_back[IDX_W-1:0];
        n_widx  = (r_widx == IDX_W'(DEPTH - 1)) ? '0 : r_widx + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.move1) begin
            mem[r_w1] <= i_store;
        end
        if (i_ctl.accept) begin
            r_rdata    <= mem[w_raddr];
            r_w1       <= r_widx;
            r_fwd_data <= i_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx  <= '0;
            r_fill  <= '0;
            r_fwd   <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_ctl.accept) begin
                r_widx  <= n_widx;
                // entry being written at this very edge comes from the bypass
                r_fwd   <= i_ctl.move1 && (w_raddr == r_w1);
                // entries at or above the fill count are unwritten since reset and read as zero
                r_rd_ok <= FILL_W'(w_raddr) < r_fill;
            end
            if (i_ctl.move1 && (r_fill != FILL_W'(DEPTH))) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    assign o_delayed = r_fwd ? r_fwd_data : (r_rd_ok ? r_rdata : '0);

    a_widx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_widx <= IDX_W'(DEPTH - 1))
        else $error("write index beyond delay depth");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.move1 && (r_fill != FILL_W'(DEPTH))) |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("fill count missed a write");

endmodule
`default_nettype wire

>>> hdl/fed_mix.sv
`default_nettype none
// Feedback and output mixing datapath: products, rounding, saturation.
module fed_mix (
    input  wire logic               i_clk,
    input  wire fed_pkg::t_pipe_ctl i_ctl,
    input  wire fed_pkg::t_smp      i_sample,
    input  wire fed_pkg::t_smp      i_delayed,
    input  wire fed_pkg::t_coef     i_coef,
    output fed_pkg::t_smp           o_store,
    output fed_pkg::t_smp           o_sample
);
    import fed_pkg::*;

    t_smp  r_smp1;
    t_prod r_pd, r_pw;
    t_smp  r_out;
    t_prod w_pfb, w_pd, w_pw;

    assign w_pfb = i_delayed * $signed({1'b0, i_coef.fb});
    assign w_pd  = r_smp1 * $signed({1'b0, i_coef.dry});
    assign w_pw  = i_delayed * $signed({1'b0, i_coef.mix});

    // written back into the delay line as stage 1 leaves
    assign o_store = sat_smp(t_acc'(r_smp1) + rnd_q16(t_acc'(w_pfb)));

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_smp1 <= i_sample;
        end
        if (i_ctl.move1) begin
            r_pd <= w_pd;
            r_pw <= w_pw;
        end
        if (i_ctl.move2) begin
            r_out <= sat_smp(rnd_q16(t_acc'(r_pd) + t_acc'(r_pw)));
        end
    end

    assign o_sample = r_out;

endmodule
`default_nettype wire

>>> hdl/feedback_echo_delay_core.sv
`default_nettype none
// Feedback echo delay: top level with pipeline control.
//
// Usage
//  - Samples enter on the s_axis channel (signed Q1.23 in tdata[23:0]) and the
//    echoed mix leaves on m_axis, one result item per input item, in order.
//  - Settings sit on the APB port: time_percent at 0x0, mix_percent at 0x4,
//    repeat_percent at 0x8, 7 bits each, reset value 50. Write only while idle.
//  - Throughput: one item per cycle while m_axis is not stalled. The delay
//    memory does at most one read and one write each cycle; a read of the entry
//    written in the same cycle is served from a bypass register.
//  - Pipeline: memory read at the accepting edge, then products, then round and
//    saturate into the output register, which drives m_axis_tvalid; the item
//    leaves at an edge with m_axis_tready high.
//  - Reset clears the pipeline, the write index and the fill count. No
//    clearing pass: entries not yet written since reset read as zero through
//    the fill count, so the block takes items as soon as reset is released.
//  - A stall on m_axis holds the output register; the three stages go on
//    filling and s_axis_tready drops only when all of them are occupied.
module feedback_echo_delay_core #(
    parameter int unsigned DELAY_DEPTH  = 24000,
    parameter int unsigned SAMPLE_RATE  = 48000,
    parameter int unsigned MAX_DELAY_MS = 500
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // APB configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [fed_pkg::APB_AW-1:0] paddr,
    input  wire logic [fed_pkg::APB_DW-1:0] pwdata,
    output logic      [fed_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    // input samples
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [23:0]                s_axis_tdata,   // [23:0] sample_in
    // output samples
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic      [23:0]                m_axis_tdata    // [23:0] sample_out
);
    import fed_pkg::*;

    localparam int unsigned IDX_W = $clog2(DELAY_DEPTH);

    t_coef            w_coef;
    logic [IDX_W-1:0] w_delay;
    t_pipe_ctl        w_ctl;
    t_smp             w_delayed, w_store, w_out;
    logic             r_v1, r_v2, r_v3;
    logic             w_adv2, w_adv3;

    // stage valids: r_v1 memory data ready, r_v2 products, r_v3 output
    assign w_adv3       = !r_v3 || m_axis_tready;
    assign w_ctl.move2  = r_v2 && w_adv3;
    assign w_adv2       = !r_v2 || w_adv3;
    assign w_ctl.move1  = r_v1 && w_adv2;
    assign s_axis_tready = !r_v1 || w_adv2;
    assign w_ctl.accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    fed_cfg #(
        .DEPTH        (DELAY_DEPTH),
        .SAMPLE_RATE  (SAMPLE_RATE),
        .MAX_DELAY_MS (MAX_DELAY_MS),
        .IDX_W        (IDX_W)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coef  (w_coef),
        .o_delay (w_delay)
    );

    fed_dline #(
        .DEPTH (DELAY_DEPTH),
        .IDX_W (IDX_W)
    ) u_dline (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_delay   (w_delay),
        .i_store   (w_store),
        .o_delayed (w_delayed)
    );

    fed_mix u_mix (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_sample  (t_smp'(s_axis_tdata)),
        .i_delayed (w_delayed),
        .i_coef    (w_coef),
        .o_store   (w_store),
        .o_sample  (w_out)
    );

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = w_out;

    // the bypass relies on the stage 1 item writing at every edge a new item enters
    a_accept_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.accept && r_v1) |-> w_ctl.move1)
        else $error("item taken while stage 1 item held back");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && !m_axis_tready) |-> !s_axis_tready)
        else $error("input ready with full pipeline stalled");

endmodule
`default_nettype wire

>>> tb/feedback_echo_delay_core_tb.sv
// Self-checking regression for the feedback echo delay core: stream traffic, APB settings.
module feedback_echo_delay_core_tb;
    import fed_pkg::*;

    // Block geometry, kept equal to the instance parameters below.
    localparam int unsigned DEPTH      = 24000;
    localparam int unsigned RATE_HZ    = 48000;
    localparam int unsigned MAX_MS     = 500;
    localparam int unsigned MIX_TOP    = 100;     // wet share saturates here
    localparam int unsigned REP_TOP    = 95;      // feedback saturates here
    localparam logic [1:0]  REG_UNUSED = 2'd3;    // address with no register behind it

    localparam int unsigned IDLE_PCT    = 34;
    localparam int unsigned PIPE_SLACK  = 8;      // extra idle wait in settle_pipe, ample for the block
    localparam int unsigned CYCLE_LIMIT = 40000;

    localparam longint SMP_HI = 64'sd8388607;
    localparam longint SMP_LO = -64'sd8388608;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [23:0]         s_axis_tdata;    // [23:0] sample_in
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [23:0]         m_axis_tdata;    // [23:0] sample_out

    feedback_echo_delay_core #(
        .DELAY_DEPTH  (DEPTH),
        .SAMPLE_RATE  (RATE_HZ),
        .MAX_DELAY_MS (MAX_MS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Mirror of the block: settings, delay line and write pointer.
    int unsigned time_pct;
    int unsigned mix_pct;
    int unsigned rep_pct;
    t_smp        echo_mem [DEPTH];
    int unsigned echo_wr;

    // Output samples still owed by the block, oldest first.
    t_smp        mixed_due [$];

    int unsigned in_idle_pct;
    int unsigned out_idle_pct;
    int unsigned fail_cnt;
    int unsigned cycle_cnt;
    t_smp        want_smp;

    // ------------------------------------------------------------------
    // Clock, cycle guard
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("feedback_echo_delay_core regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Fixed-point helpers of the mirror
    // ------------------------------------------------------------------
    // round half up to the nearest Q16 step: floor((v + 2^15) / 2^16)
    function automatic longint q16_round(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic t_smp clip24(input longint v);
        if (v > SMP_HI) begin
            return t_smp'(SMP_HI);
        end else if (v < SMP_LO) begin
            return t_smp'(SMP_LO);
        end
        return t_smp'(v);
    endfunction

    function automatic longint pct_q16(input longint p);
        return (p * 65536 + 50) / 100;
    endfunction

    // One sample through the echo: reads the tap, writes the feedback sum,
    // returns the dry/wet blend and moves the write pointer on.
    function automatic t_smp echo_predict(input t_smp x);
        longint      mix;
        longint      dry;
        longint      fb;
        longint      dly;
        longint      tap;
        longint      store;
        longint      acc;
        int unsigned rd;
        mix = pct_q16((mix_pct > MIX_TOP) ? MIX_TOP : mix_pct);
        dry = 65536 - mix;
        fb  = pct_q16((rep_pct > REP_TOP) ? REP_TOP : rep_pct);
        dly = ((longint'(time_pct) * MAX_MS) / 100) * RATE_HZ / 1000;
        if (dly >= DEPTH) begin
            dly = DEPTH - 1;
        end
        if (dly == 0) begin
            dly = 1;
        end
        rd    = (echo_wr + DEPTH - int'(dly)) % DEPTH;
        tap   = echo_mem[rd];
        store = longint'(x) + q16_round(tap * fb);
        echo_mem[echo_wr] = clip24(store);
        acc     = longint'(x) * dry + tap * mix;
        echo_wr = (echo_wr + 1) % DEPTH;
        return clip24(q16_round(acc));
    endfunction

    // Biased draw: mostly full range, some quiet samples, some rails, zeros and minus ones.
    function automatic t_smp rand_sample();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            case ($urandom_range(3))
                0: return t_smp'(SMP_HI);
                1: return t_smp'(SMP_LO);
                2: return '0;
                default: return '1;
            endcase
        end else if (pick <= 2) begin
            return t_smp'($signed($urandom_range(2000)) - 1000);
        end
        return t_smp'($urandom());
    endfunction

    // ------------------------------------------------------------------
    // APB access; called at a falling edge, returns at a falling edge
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [1:0] idx, input logic [APB_DW-1:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // only the low seven bits land; an empty address changes nothing
        case (idx)
            REG_TIME:   time_pct = val[PCT_W-1:0];
            REG_MIX:    mix_pct  = val[PCT_W-1:0];
            REG_REPEAT: rep_pct  = val[PCT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_check(input logic [1:0] idx, input int unsigned want);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== APB_DW'(want)) begin
            fail_cnt++;
            $error("prdata at 0x%0h: expected %0d, got %0d", paddr, want, prdata);
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apb_settings(input int unsigned t, input int unsigned m,
                                input int unsigned r);
        apb_write(REG_TIME, t);
        apb_write(REG_MIX, m);
        apb_write(REG_REPEAT, r);
    endtask

    // ------------------------------------------------------------------
    // Stream side
    // ------------------------------------------------------------------
    // tvalid is left high after acceptance so back-to-back items need no
    // toggle; it only drops for a gap or in settle_pipe.
    task automatic send_sample(input t_smp x);
        while ($urandom_range(99) < in_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = x;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        mixed_due.push_back(echo_predict(x));
        @(negedge i_clk);
    endtask

    // Every item yields a result, so an empty queue plus the pipe slack
    // means the block is idle and settings may change.
    task automatic settle_pipe();
        s_axis_tvalid = 1'b0;
        while (mixed_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (mixed_due.size() == 0) begin
                fail_cnt++;
                $error("sample_out: no item expected, got %0d", $signed(m_axis_tdata));
            end else begin
                want_smp = mixed_due.pop_front();
                if (m_axis_tdata !== want_smp) begin
                    fail_cnt++;
                    $error("sample_out: expected %0d, got %0d",
                           want_smp, $signed(m_axis_tdata));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset values read back; default delay is 12000 so only the dry half shows.
    task automatic test_reset_state();
        apb_check(REG_TIME, RST_PCT);
        apb_check(REG_MIX, RST_PCT);
        apb_check(REG_REPEAT, RST_PCT);
        send_sample(t_smp'(SMP_HI));
        send_sample(t_smp'(SMP_LO));
        send_sample('0);
        send_sample('1);
        settle_pipe();
    endtask

    // One-sample delay, fully wet, feedback past its cap: rails drive the
    // feedback sum into saturation both ways.
    task automatic test_rails_feedback();
        apb_settings(0, MIX_TOP, 127);
        apb_check(REG_REPEAT, 127);
        repeat (5) send_sample(t_smp'(SMP_HI));
        repeat (4) send_sample(t_smp'(SMP_LO));
        send_sample('0);
        send_sample(t_smp'(1));
        send_sample('1);
        settle_pipe();
    endtask

    // Delay beyond the line clamps, wet share above 100 clamps, junk above
    // bit 6 is dropped and a write to the empty address is ignored.
    task automatic test_clamps();
        apb_settings(127, 127, REP_TOP);
        apb_write(REG_UNUSED, 32'h0000_0055);
        apb_write(REG_MIX, 32'hFFFF_FF00 | 32'(MIX_TOP));
        apb_check(REG_MIX, MIX_TOP);
        apb_check(REG_TIME, 127);
        send_sample(t_smp'(SMP_HI));
        send_sample(t_smp'(12345));
        settle_pipe();
        apb_settings(MIX_TOP, 0, 0);
        send_sample(t_smp'(SMP_LO));
        send_sample(t_smp'(-777));
        settle_pipe();
    endtask

    // Random settings per phase, short delays mostly; only a one-sample delay
    // brings its echoes back within the phase, where they stack through feedback.
    task automatic test_random_mix();
        int unsigned t;
        for (int ph = 0; ph < 5; ph++) begin
            case ($urandom_range(4))
                0: t = 0;
                1: t = 1;
                2: t = $urandom_range(3);
                3: t = 2;
                default: t = $urandom_range(127);
            endcase
            apb_settings(t, $urandom_range(127), $urandom_range(127));
            repeat (80) send_sample(rand_sample());
            settle_pipe();
        end
    endtask

    // Unbroken traffic on both sides: a 240-sample delay run long enough
    // for its echoes to come back, then a one-sample delay at the cap.
    task automatic test_back_to_back();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        apb_settings(1, 60, 80);
        repeat (300) send_sample(rand_sample());
        settle_pipe();
        apb_settings(0, 30, REP_TOP);
        repeat (100) send_sample(rand_sample());
        settle_pipe();
        in_idle_pct  = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        in_idle_pct   = IDLE_PCT;
        out_idle_pct  = IDLE_PCT;
        fail_cnt      = 0;
        cycle_cnt     = 0;
        time_pct      = RST_PCT;
        mix_pct       = RST_PCT;
        rep_pct       = RST_PCT;
        echo_wr       = 0;
        foreach (echo_mem[k]) begin
            echo_mem[k] = '0;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_rails_feedback();
        test_clamps();
        test_random_mix();
        test_back_to_back();

        if (fail_cnt == 0) begin
            $display("feedback_echo_delay_core regression: pass");
        end else begin
            $display("feedback_echo_delay_core regression: fail");
        end
        $finish;
    end

endmodule
